>>> design/ir_wall_sensor_filtered_detector_core_macros.svh
// Assertion helpers shared by the detector RTL.
// Each macro expects clk and rst_n in the enclosing module.
`ifndef IR_WALL_SENSOR_FILTERED_DETECTOR_CORE_MACROS_SVH
`define IR_WALL_SENSOR_FILTERED_DETECTOR_CORE_MACROS_SVH

// Same-cycle implication, checked out of reset
`define IWSFD_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset
`define IWSFD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/iwsfd_pkg.sv
package iwsfd_pkg;

  // Block dimensions
  localparam int CAL_POINTS    = 10;
  localparam int SENSOR_COUNT  = 3;
  localparam int SAMPLE_BITS   = 12;
  localparam int SENSOR_W      = 2;
  localparam int SENSOR_ADDR_W = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;
  localparam int CAL_IDX_W     = $clog2(CAL_POINTS);
  localparam logic [SENSOR_W:0] SENSOR_LIMIT = (SENSOR_W + 1)'(SENSOR_COUNT);

  // Datapath widths
  localparam int CAL_LEVEL_W  = 16;
  localparam int DIST_W       = 16;
  localparam int WEIGHT_W     = 9;
  localparam int WEIGHT_SHIFT = 8;
  localparam int SPAN_W       = DIST_W + 1;
  localparam int PROD_W       = 2 * SPAN_W;
  localparam int MAG_W        = 2 * DIST_W;
  localparam int DIV_CYCLES   = MAG_W / 2;
  localparam int DIV_CNT_W    = $clog2(DIV_CYCLES);
  localparam int SPROD_W      = WEIGHT_W + 1 + SPAN_W;

  // Configuration port
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  // Constants and reset values
  localparam logic [DIST_W-1:0]   NO_WALL_DIST      = 16'd63936;
  localparam logic [WEIGHT_W-1:0] FULL_WEIGHT       = 9'd256;
  localparam logic [DIST_W-1:0]   WALL_ON_RESET     = 16'd256;
  localparam logic [DIST_W-1:0]   WALL_OFF_RESET    = 16'd320;
  localparam logic [DIST_W-1:0]   APPROACH_ON_RESET = 16'd128;
  localparam logic [DIST_W-1:0]   APPROACH_OFF_RESET = 16'd160;
  localparam logic [WEIGHT_W-1:0] WEIGHT_RESET      = 9'd77;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_WALL_ON      = 3'd0,
    CFG_WALL_OFF     = 3'd1,
    CFG_APPROACH_ON  = 3'd2,
    CFG_APPROACH_OFF = 3'd3,
    CFG_WEIGHT       = 3'd4
  } cfg_index_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RANGE,
    ST_SEARCH,
    ST_MUL,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_SMOOTH,
    ST_DONE
  } ctrl_state_t;

  // One per-sensor entry of the state memory
  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              wall;
    logic              approach;
  } state_word_t;

  localparam state_word_t STATE_RESET =
    '{distance: NO_WALL_DIST, wall: 1'b0, approach: 1'b0};

  // Calibration points: reflected level falls as distance grows
  localparam logic [CAL_LEVEL_W-1:0] CAL_LEVEL [SENSOR_COUNT][CAL_POINTS] = '{
    '{16'd327, 16'd122, 16'd66, 16'd44, 16'd33, 16'd27, 16'd24, 16'd21, 16'd20, 16'd18},
    '{16'd225, 16'd107, 16'd63, 16'd43, 16'd34, 16'd30, 16'd26, 16'd23, 16'd22, 16'd20},
    '{16'd180, 16'd86,  16'd56, 16'd38, 16'd31, 16'd27, 16'd24, 16'd22, 16'd21, 16'd20}
  };

  localparam logic [DIST_W-1:0] CAL_DIST [SENSOR_COUNT][CAL_POINTS] = '{
    '{16'd64, 16'd128, 16'd192, 16'd256, 16'd320, 16'd384, 16'd448, 16'd512, 16'd576, 16'd640},
    '{16'd64, 16'd128, 16'd192, 16'd256, 16'd320, 16'd384, 16'd448, 16'd512, 16'd576, 16'd640},
    '{16'd64, 16'd128, 16'd192, 16'd256, 16'd320, 16'd384, 16'd448, 16'd512, 16'd576, 16'd640}
  };

endpackage

>>> design/iwsfd_ram.sv
module iwsfd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                          wr_data,
  input  logic                                      rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                          rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port, holds between reads
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> design/iwsfd_div.sv
module iwsfd_div import iwsfd_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [MAG_W-1:0]       dividend,
  input  logic [CAL_LEVEL_W-1:0] divisor,
  output logic                   done,
  output logic [MAG_W-1:0]       quotient
);

  logic                   busy_r;
  logic                   done_r;
  logic [DIV_CNT_W-1:0]   cnt_r;
  logic [MAG_W-1:0]       quo_r;
  logic [CAL_LEVEL_W-1:0] rem_r;
  logic [CAL_LEVEL_W-1:0] den_r;

  logic [CAL_LEVEL_W:0]   t1, t2, r1_full, r2_full;
  logic                   ge1, ge2;
  logic [MAG_W-1:0]       quo_nxt;
  logic [CAL_LEVEL_W-1:0] rem_nxt;

  // Two restoring steps per cycle: shift in a dividend bit, subtract if it fits
  always_comb begin
    t1      = {rem_r, quo_r[MAG_W-1]};
    ge1     = t1 >= {1'b0, den_r};
    r1_full = ge1 ? (t1 - {1'b0, den_r}) : t1;
    t2      = {r1_full[CAL_LEVEL_W-1:0], quo_r[MAG_W-2]};
    ge2     = t2 >= {1'b0, den_r};
    r2_full = ge2 ? (t2 - {1'b0, den_r}) : t2;
    rem_nxt = r2_full[CAL_LEVEL_W-1:0];
    quo_nxt = {quo_r[MAG_W-3:0], ge1, ge2};
  end

  // Control: count the division steps down from start, then pulse done
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= DIV_CNT_W'(DIV_CYCLES - 1);
      end else if (busy_r) begin
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  // Load operands, then shift quotient and remainder
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      den_r <= divisor;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

>>> design/ir_wall_sensor_filtered_detector_core.sv
// IR wall sensor detector.
// Input channel (in_valid/in_ready): one item per sensor reading, carrying the
// sensor number and the lit and ambient ADC samples. An item for a sensor
// number with no calibration table is dropped and gives no result.
// Result channel (out_valid/out_ready): one item per kept input, with the
// reflected level, the smoothed distance in 1/64 inch and the two flags.
// Configuration channel (cfg_valid/cfg_ready): thresholds and smoothing
// weight, always ready out of reset; write only while no item is in flight.
// An item whose level lies outside the calibration range skips the
// segment search and the interpolation. Inside the range, the segment
// search (one table point per cycle) and the radix-4 divider of the
// interpolation take most of the time. One item is worked on at a time;
// the next is accepted the cycle after a result is registered.
// Per-sensor state sits in a small RAM with a registered read; per-entry
// valid bits give reset values for entries not yet written, so reset
// needs no clearing pass.
// When the receiver stalls, the result waits in the output register; a new
// item is still accepted, and its result waits until the register frees.
`include "ir_wall_sensor_filtered_detector_core_macros.svh"

module ir_wall_sensor_filtered_detector_core import iwsfd_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,

  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [SENSOR_W-1:0]    in_sensor,
  input  logic [SAMPLE_BITS-1:0] in_lit_sample,
  input  logic [SAMPLE_BITS-1:0] in_ambient_sample,

  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [SENSOR_W-1:0]    out_sensor_echo,
  output logic [SAMPLE_BITS-1:0] out_reflected_level,
  output logic [DIST_W-1:0]      out_smoothed_distance,
  output logic                   out_wall_present,
  output logic                   out_wall_approaching,

  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  ctrl_state_t state_r, state_nxt;

  // Configuration registers
  logic [DIST_W-1:0]   wall_on_r, wall_off_r, appr_on_r, appr_off_r;
  logic [WEIGHT_W-1:0] weight_r;

  // Item registers
  logic [SENSOR_W-1:0]      sel_r;
  logic [SAMPLE_BITS-1:0]   level_r;
  logic [CAL_IDX_W-1:0]     k_r;
  logic [CAL_LEVEL_W-1:0]   hl_r, den_r;
  logic signed [SPAN_W-1:0] span_r;
  logic [DIST_W-1:0]        base_r, fresh_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [SPROD_W-1:0] sprod_r;
  logic [SENSOR_COUNT-1:0]  valid_r;
  logic                     out_valid_r;

  // Handshake and control
  logic in_take, sel_ok, out_free;
  logic ram_rd_en, ram_we, div_start, div_done;

  // Table search
  logic [CAL_IDX_W-1:0]   k_next_idx;
  logic [CAL_LEVEL_W-1:0] level_ext, seg_hi, seg_lo;
  logic                   seg_hit, search_last, at_low_end, at_high_end;
  logic [SAMPLE_BITS-1:0] level_in;

  // Interpolation
  logic signed [PROD_W-1:0] prod_nxt, q_ext, base_ext, interp_s;
  logic [MAG_W-1:0]         prod_mag, div_quo;
  logic [DIST_W-1:0]        interp_dist;

  // Smoothing and flags
  state_word_t               ram_rd_data, old_word, new_word;
  logic [DIST_W-1:0]         old_dist, next_dist;
  logic signed [SPAN_W-1:0]  diff_s;
  logic [WEIGHT_W-1:0]       w_eff;
  logic signed [SPROD_W-1:0] sprod_nxt, sadj, sstep, old_ext, next_s;
  logic                      wall_nxt, appr_nxt;

  // ---------------------------------------------------------------------
  // Input side
  assign in_take  = in_valid && in_ready;
  assign sel_ok   = {1'b0, in_sensor} < SENSOR_LIMIT;
  assign out_free = !out_valid_r || out_ready;
  assign level_in = (in_lit_sample > in_ambient_sample) ?
                    (in_lit_sample - in_ambient_sample) : '0;

  // Segment compare against the constant table
  assign level_ext   = CAL_LEVEL_W'(level_r);
  assign k_next_idx  = k_r + CAL_IDX_W'(1);
  assign seg_hi      = CAL_LEVEL[sel_r][k_r];
  assign seg_lo      = CAL_LEVEL[sel_r][k_next_idx];
  assign seg_hit     = (level_ext <= seg_hi) && (level_ext >= seg_lo) && (seg_hi > seg_lo);
  assign search_last = k_r == CAL_IDX_W'(CAL_POINTS - 2);
  assign at_low_end  = level_ext <= CAL_LEVEL[sel_r][CAL_POINTS-1];
  assign at_high_end = level_ext >= CAL_LEVEL[sel_r][0];

  // Interpolation numerator, its magnitude and the signed result
  assign prod_nxt    = $signed({1'b0, hl_r}) * span_r;
  assign prod_mag    = prod_r[PROD_W-1] ? MAG_W'(-prod_r) : MAG_W'(prod_r);
  assign q_ext       = $signed(PROD_W'(div_quo));
  assign base_ext    = $signed(PROD_W'(base_r));
  assign interp_s    = base_ext + (prod_r[PROD_W-1] ? -q_ext : q_ext);
  assign interp_dist = interp_s[PROD_W-1] ? '0 : interp_s[DIST_W-1:0];

  // Old entry: memory data once written, reset value before
  assign old_word = valid_r[sel_r] ? ram_rd_data : STATE_RESET;
  assign old_dist = old_word.distance;

  // Blend: old + trunc(w * (new - old) / 256), rounding toward zero
  assign w_eff     = (weight_r > FULL_WEIGHT) ? FULL_WEIGHT : weight_r;
  assign diff_s    = $signed({1'b0, fresh_r}) - $signed({1'b0, old_dist});
  assign sprod_nxt = $signed({1'b0, w_eff}) * diff_s;
  assign sadj      = sprod_r + (sprod_r[SPROD_W-1] ?
                     SPROD_W'((1 << WEIGHT_SHIFT) - 1) : SPROD_W'(0));
  assign sstep     = sadj >>> WEIGHT_SHIFT;
  assign old_ext   = $signed(SPROD_W'(old_dist));
  assign next_s    = old_ext + sstep;
  assign next_dist = next_s[DIST_W-1:0];

  // Hysteresis on the new running distance
  assign wall_nxt = old_word.wall ? !(next_dist >= wall_off_r) : (next_dist <= wall_on_r);
  assign appr_nxt = old_word.approach ? !(next_dist >= appr_off_r) : (next_dist <= appr_on_r);
  assign new_word = '{distance: next_dist, wall: wall_nxt, approach: appr_nxt};

  // ---------------------------------------------------------------------
  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_take && sel_ok) state_nxt = ST_RANGE;
      end
      ST_RANGE: begin
        state_nxt = (at_low_end || at_high_end) ? ST_SMOOTH : ST_SEARCH;
      end
      ST_SEARCH: begin
        if (seg_hit) state_nxt = ST_MUL;
        else if (search_last) state_nxt = ST_SMOOTH;
      end
      ST_MUL:       state_nxt = ST_DIV_START;
      ST_DIV_START: state_nxt = ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (div_done) state_nxt = ST_SMOOTH;
      end
      ST_SMOOTH:    state_nxt = ST_DONE;
      ST_DONE: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default:      state_nxt = ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    in_ready  = 1'b0;
    ram_we    = 1'b0;
    div_start = 1'b0;
    unique case (state_r)
      ST_IDLE:      in_ready  = rst_n;
      ST_DIV_START: div_start = 1'b1;
      ST_DONE:      ram_we    = out_free;
      default: ;
    endcase
  end

  assign ram_rd_en = in_take && sel_ok;
  assign cfg_ready = rst_n;

  // ---------------------------------------------------------------------
  // Control registers and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
      wall_on_r   <= WALL_ON_RESET;
      wall_off_r  <= WALL_OFF_RESET;
      appr_on_r   <= APPROACH_ON_RESET;
      appr_off_r  <= APPROACH_OFF_RESET;
      weight_r    <= WEIGHT_RESET;
    end else begin
      state_r <= state_nxt;
      if (ram_we) begin
        valid_r[sel_r] <= 1'b1;
      end
      // Hold the result until taken
      if (ram_we) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index_t'(cfg_index))
          CFG_WALL_ON:      wall_on_r  <= cfg_data[DIST_W-1:0];
          CFG_WALL_OFF:     wall_off_r <= cfg_data[DIST_W-1:0];
          CFG_APPROACH_ON:  appr_on_r  <= cfg_data[DIST_W-1:0];
          CFG_APPROACH_OFF: appr_off_r <= cfg_data[DIST_W-1:0];
          CFG_WEIGHT:       weight_r   <= cfg_data[WEIGHT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Item datapath registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          sel_r   <= in_sensor;
          level_r <= level_in;
        end
      end
      ST_RANGE: begin
        k_r <= '0;
        if (at_low_end) fresh_r <= NO_WALL_DIST;
        else if (at_high_end) fresh_r <= CAL_DIST[sel_r][0];
      end
      ST_SEARCH: begin
        if (seg_hit) begin
          hl_r   <= seg_hi - level_ext;
          den_r  <= seg_hi - seg_lo;
          span_r <= $signed({1'b0, CAL_DIST[sel_r][k_next_idx]}) -
                    $signed({1'b0, CAL_DIST[sel_r][k_r]});
          base_r <= CAL_DIST[sel_r][k_r];
        end else begin
          k_r <= k_next_idx;
          if (search_last) fresh_r <= NO_WALL_DIST;
        end
      end
      ST_MUL:      prod_r <= prod_nxt;
      ST_DIV_WAIT: begin
        if (div_done) fresh_r <= interp_dist;
      end
      ST_SMOOTH:   sprod_r <= sprod_nxt;
      default: ;
    endcase
  end

  // Result register
  always_ff @(posedge clk) begin
    if (ram_we) begin
      out_sensor_echo       <= sel_r;
      out_reflected_level   <= level_r;
      out_smoothed_distance <= next_dist;
      out_wall_present      <= wall_nxt;
      out_wall_approaching  <= appr_nxt;
    end
  end

  assign out_valid = out_valid_r;

  // ---------------------------------------------------------------------
  // Per-sensor state memory
  iwsfd_ram #(
    .WIDTH ($bits(state_word_t)),
    .DEPTH (SENSOR_COUNT)
  ) u_state_ram (
    .clk     (clk),
    .we      (ram_we),
    .wr_addr (sel_r[SENSOR_ADDR_W-1:0]),
    .wr_data (new_word),
    .rd_en   (ram_rd_en),
    .rd_addr (in_sensor[SENSOR_ADDR_W-1:0]),
    .rd_data (ram_rd_data)
  );

  // Interpolation divider
  iwsfd_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (prod_mag),
    .divisor  (den_r),
    .done     (div_done),
    .quotient (div_quo)
  );

  // ---------------------------------------------------------------------
  // Assertions
  `IWSFD_ASSERT_NEXT(a_writeback_gives_result, ram_we, out_valid_r,
    "write-back did not register a result")
  `IWSFD_ASSERT_NEXT(a_accept_starts_work, in_take && sel_ok, state_r == ST_RANGE,
    "accepted item did not start work")
  `IWSFD_ASSERT_IMPLIES(a_search_in_table, state_r == ST_SEARCH,
    k_r <= CAL_IDX_W'(CAL_POINTS - 2), "segment search ran past the table")
  `IWSFD_ASSERT_IMPLIES(a_blend_between, ram_we,
    (next_dist >= old_dist && next_dist <= fresh_r) ||
    (next_dist <= old_dist && next_dist >= fresh_r),
    "smoothed distance outside old and new distance")

endmodule
